@@ hdl/w2v_pkg.sv @@
package w2v_pkg;

  // Field widths
  localparam int ANGLE_BITS      = 16;
  localparam int COORD_BITS      = 32;
  localparam int SINE_TABLE_BITS = 10;

  // Trig values are Q1.16 whatever the position format
  localparam int TRIG_FRAC = 16;
  localparam int TRIG_W    = TRIG_FRAC + 2;
  localparam int ROM_W     = TRIG_FRAC + 1;
  localparam int TABLE_N   = 1 << SINE_TABLE_BITS;
  localparam int IDX_W     = SINE_TABLE_BITS + 1;

  // Stream and configuration port widths
  localparam int IN_W        = 2 * COORD_BITS + ANGLE_BITS;
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = IN_TDATA_W;
  localparam int CFG_W       = (COORD_BITS > ANGLE_BITS) ? COORD_BITS : ANGLE_BITS;
  localparam int CFG_IDX_W   = 2;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VEHICLE_X       = 2'd0,
    REG_VEHICLE_Y       = 2'd1,
    REG_VEHICLE_HEADING = 2'd2
  } cfg_reg_t;

  // Heading quadrants
  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  // Pose as seen by the datapath
  typedef struct packed {
    logic signed [COORD_BITS-1:0] vx;
    logic signed [COORD_BITS-1:0] vy;
    logic [ANGLE_BITS-1:0]        vh;
    logic signed [TRIG_W-1:0]     cosine;
    logic signed [TRIG_W-1:0]     sine;
  } pose_t;

  // Quarter-wave sine table, built at elaboration with a Taylor series in Q2.30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_TRIG    = 64'd1 << TRIG_FRAC;
  localparam logic [63:0] TAYLOR_DIV [1:12] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  typedef logic [ROM_W-1:0] sine_rom_t [0:TABLE_N];

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t          rom;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        r;
    for (int i = 0; i <= TABLE_N; i++) begin
      x = (HALF_PI_Q30 * 64'(i) + (64'd1 << (SINE_TABLE_BITS - 1))) >> SINE_TABLE_BITS;
      x2 = (x * x) >> 30;
      term = x;
      sum = $signed(x);
      for (int k = 1; k <= 12; k++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[k];
        if (k % 2 == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = 64'sd0;
      end
      r = (64'(sum) + (64'd1 << (29 - TRIG_FRAC))) >> (30 - TRIG_FRAC);
      if (r > ONE_TRIG) begin
        r = ONE_TRIG;
      end
      rom[i] = r[ROM_W-1:0];
    end
    return rom;
  endfunction

  // Table index from the heading: the bits below the quadrant, scaled to the table
  function automatic logic [SINE_TABLE_BITS-1:0] angle_index(logic [ANGLE_BITS-1:0] h);
    logic [ANGLE_BITS+SINE_TABLE_BITS-1:0] ext;
    ext = {h, {SINE_TABLE_BITS{1'b0}}};
    ext[ANGLE_BITS+SINE_TABLE_BITS-1:ANGLE_BITS+SINE_TABLE_BITS-2] = 2'b00;
    ext = ext >> (ANGLE_BITS - 2);
    return ext[SINE_TABLE_BITS-1:0];
  endfunction

endpackage

@@ hdl/w2v_trig.sv @@
module w2v_trig import w2v_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [ANGLE_BITS-1:0]    heading,
  output logic signed [TRIG_W-1:0] cosine,
  output logic signed [TRIG_W-1:0] sine,
  output logic                     busy
);

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  logic                       ld1;
  logic                       ld2;
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [IDX_W-1:0]           nidx;
  logic [ROM_W-1:0]           a_q;
  logic [ROM_W-1:0]           b_q;
  quad_t                      quad_q;
  logic signed [TRIG_W-1:0]   a_s;
  logic signed [TRIG_W-1:0]   b_s;
  logic signed [TRIG_W-1:0]   sine_next;
  logic signed [TRIG_W-1:0]   cosine_next;

  // Table addresses for sine and its complement
  assign idx  = angle_index(heading);
  assign nidx = IDX_W'(TABLE_N) - {1'b0, idx};

  // Advance the two-step load
  always_ff @(posedge clk) begin
    if (rst) begin
      ld1 <= 1'b0;
      ld2 <= 1'b0;
    end else begin
      ld1 <= start;
      ld2 <= ld1;
    end
  end

  // Read both table ports
  always_ff @(posedge clk) begin
    a_q    <= SINE_ROM[{1'b0, idx}];
    b_q    <= SINE_ROM[nidx];
    quad_q <= quad_t'(heading[ANGLE_BITS-1:ANGLE_BITS-2]);
  end

  // Fold the quarter wave into the full circle
  assign a_s = $signed({1'b0, a_q});
  assign b_s = $signed({1'b0, b_q});

  always_comb begin
    case (quad_q)
      QUAD_0: begin
        sine_next   = a_s;
        cosine_next = b_s;
      end
      QUAD_1: begin
        sine_next   = b_s;
        cosine_next = -a_s;
      end
      QUAD_2: begin
        sine_next   = -a_s;
        cosine_next = -b_s;
      end
      default: begin
        sine_next   = -b_s;
        cosine_next = a_s;
      end
    endcase
  end

  // Hold the pose trig values
  always_ff @(posedge clk) begin
    if (rst) begin
      cosine <= TRIG_W'(ONE_TRIG);
      sine   <= '0;
    end else if (ld2) begin
      cosine <= cosine_next;
      sine   <= sine_next;
    end
  end

  assign busy = ld1 | ld2;

endmodule

@@ hdl/w2v_pipe.sv @@
module w2v_pipe import w2v_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  pose_t                        pose,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic [ANGLE_BITS-1:0]        point_heading,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] rel_x,
  output logic signed [COORD_BITS-1:0] rel_y,
  output logic [ANGLE_BITS-1:0]        rel_heading,
  output logic                         saturated
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = DW + TRIG_W;
  localparam int SW = PW + 1;
  localparam int HW = SW - TRIG_FRAC;
  localparam logic [SW-1:0] RND = SW'(1) << (TRIG_FRAC - 1);

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  logic signed [DW-1:0]  dx1, dy1;
  logic [ANGLE_BITS-1:0] rh1, rh2, rh3;
  logic signed [PW-1:0]  p_xc, p_ys, p_yc, p_xs;
  logic [SW-1:0]         sx3, sy3;
  logic [HW-1:0]         hx, hy;
  logic                  hi_x, lo_x, hi_y, lo_y;
  logic [COORD_BITS-1:0] cx, cy;

  // Stage readiness: a stage takes an item when empty or when it empties
  assign rdy4     = !v4 || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // Stage 1: offsets from the vehicle, relative heading
  always_ff @(posedge clk) begin
    if (rdy1) begin
      dx1 <= $signed({point_x[COORD_BITS-1], point_x}) - $signed({pose.vx[COORD_BITS-1], pose.vx});
      dy1 <= $signed({point_y[COORD_BITS-1], point_y}) - $signed({pose.vy[COORD_BITS-1], pose.vy});
      rh1 <= point_heading - pose.vh;
    end
  end

  // Stage 2: four rotation products
  always_ff @(posedge clk) begin
    if (rdy2) begin
      p_xc <= PW'(dx1 * pose.cosine);
      p_ys <= PW'(dy1 * pose.sine);
      p_yc <= PW'(dy1 * pose.cosine);
      p_xs <= PW'(dx1 * pose.sine);
      rh2  <= rh1;
    end
  end

  // Stage 3: sum the products with the half-up rounding term
  always_ff @(posedge clk) begin
    if (rdy3) begin
      sx3 <= {p_xc[PW-1], p_xc} + {p_ys[PW-1], p_ys} + RND;
      sy3 <= {p_yc[PW-1], p_yc} - {p_xs[PW-1], p_xs} + RND;
      rh3 <= rh2;
    end
  end

  // Drop the fraction and clamp to the coordinate range
  assign hx   = sx3[SW-1:TRIG_FRAC];
  assign hy   = sy3[SW-1:TRIG_FRAC];
  assign hi_x = !hx[HW-1] && (|hx[HW-2:COORD_BITS-1]);
  assign lo_x = hx[HW-1] && !(&hx[HW-2:COORD_BITS-1]);
  assign hi_y = !hy[HW-1] && (|hy[HW-2:COORD_BITS-1]);
  assign lo_y = hy[HW-1] && !(&hy[HW-2:COORD_BITS-1]);

  always_comb begin
    cx = hx[COORD_BITS-1:0];
    if (hi_x) cx = {1'b0, {(COORD_BITS-1){1'b1}}};
    if (lo_x) cx = {1'b1, {(COORD_BITS-1){1'b0}}};
    cy = hy[COORD_BITS-1:0];
    if (hi_y) cy = {1'b0, {(COORD_BITS-1){1'b1}}};
    if (lo_y) cy = {1'b1, {(COORD_BITS-1){1'b0}}};
  end

  // Stage 4: output register
  always_ff @(posedge clk) begin
    if (rdy4) begin
      rel_x       <= $signed(cx);
      rel_y       <= $signed(cy);
      rel_heading <= rh3;
      saturated   <= hi_x | lo_x | hi_y | lo_y;
    end
  end

  assign out_valid = v4;

endmodule

@@ hdl/world_to_vehicle_frame_transform_top.sv @@
// Channel  Handshake               Payload
// s_       s_tvalid / s_tready     s_tdata: point_x, point_y, point_heading
// m_       m_tvalid / m_tready     m_tdata: rel_x, rel_y, rel_heading; m_tuser: saturated
// cfg_     cfg_valid / cfg_ready   cfg_index, cfg_data (vehicle_x, vehicle_y, vehicle_heading)
//
// One item per cycle unless the output stalls or a heading reload is running; an accepted
// item moves through the stages into the output register, where it can leave. Four register stages set this depth:
// offset, multiply, sum, and clamp into the output register.
// A heading write is followed by a table read and a fold into the trig registers, during
// which cfg_ready and s_tready are low. Reset clears the pose and the pipeline.
// Stalls on m_tready hold each full stage; empty stages still take new items.
module world_to_vehicle_frame_transform_top import w2v_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // point_x, point_y, point_heading, zero pad
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // rel_x, rel_y, rel_heading, zero pad
  output logic                   m_tuser,   // saturated
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  logic signed [COORD_BITS-1:0] vehicle_x;
  logic signed [COORD_BITS-1:0] vehicle_y;
  logic [ANGLE_BITS-1:0]        vehicle_heading;
  logic                         cfg_wr;
  logic                         hdg_wr;
  logic                         trig_busy;
  logic signed [TRIG_W-1:0]     cosine;
  logic signed [TRIG_W-1:0]     sine;
  pose_t                        pose;
  logic                         pipe_ready;
  logic signed [COORD_BITS-1:0] rel_x;
  logic signed [COORD_BITS-1:0] rel_y;
  logic [ANGLE_BITS-1:0]        rel_heading;

  assign cfg_ready = !trig_busy;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign hdg_wr    = cfg_wr && (cfg_index == REG_VEHICLE_HEADING);

  // Pose registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vehicle_x       <= '0;
      vehicle_y       <= '0;
      vehicle_heading <= '0;
    end else if (cfg_wr) begin
      if (cfg_index == REG_VEHICLE_X) vehicle_x <= $signed(cfg_data[COORD_BITS-1:0]);
      if (cfg_index == REG_VEHICLE_Y) vehicle_y <= $signed(cfg_data[COORD_BITS-1:0]);
      if (hdg_wr) vehicle_heading <= cfg_data[ANGLE_BITS-1:0];
    end
  end

  w2v_trig u_trig (
    .clk     (clk),
    .rst     (rst),
    .start   (hdg_wr),
    .heading (vehicle_heading),
    .cosine  (cosine),
    .sine    (sine),
    .busy    (trig_busy)
  );

  assign pose = '{vx: vehicle_x, vy: vehicle_y, vh: vehicle_heading,
                  cosine: cosine, sine: sine};

  // Hold input while the trig values reload
  assign s_tready = pipe_ready && !trig_busy;

  w2v_pipe u_pipe (
    .clk           (clk),
    .rst           (rst),
    .pose          (pose),
    .in_valid      (s_tvalid && !trig_busy),
    .in_ready      (pipe_ready),
    .point_x       ($signed(s_tdata[COORD_BITS-1:0])),
    .point_y       ($signed(s_tdata[2*COORD_BITS-1:COORD_BITS])),
    .point_heading (s_tdata[IN_W-1:2*COORD_BITS]),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .rel_x         (rel_x),
    .rel_y         (rel_y),
    .rel_heading   (rel_heading),
    .saturated     (m_tuser)
  );

  assign m_tdata = OUT_TDATA_W'({rel_heading, rel_y, rel_x});

endmodule
